[hw/rtl/gdnc_pkg.sv]
// ----------------------------------------------------------------------------
// gdnc_pkg
// Shared widths, constants and month tables for the Gregorian day number
// converter.
// ----------------------------------------------------------------------------
package gdnc_pkg;

    // beat layout
    localparam int YEAR_W     = 14;
    localparam int MONTH_W    = 4;
    localparam int DAY_W      = 5;
    localparam int DAYNUM_W   = 23;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 48;

    localparam int NUM_STAGES = 7;

    // functions selected by tuser
    localparam logic FUNC_TO_DAYS = 1'b0;
    localparam logic FUNC_TO_DATE = 1'b1;

    // valid input ranges
    localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;
    localparam logic [MONTH_W-1:0] MONTH_MAX = 4'd12;
    localparam logic signed [DAYNUM_W-1:0] DAYNUM_MIN = -23'sd730119;
    localparam logic signed [DAYNUM_W-1:0] DAYNUM_MAX = 23'sd2921939;

    // date -> days
    localparam logic [14:0] YEAR_BIAS  = 15'd4800;
    localparam logic [22:0] DAYS_BIAS  = 23'd2483712;
    localparam logic [8:0]  DAYS_YEAR  = 9'd365;
    localparam logic [12:0] RECIP_100  = 13'd5243;      // x/100 = x*5243 >> 19
    localparam int          SHIFT_100  = 19;

    // days -> date
    localparam logic [22:0] EPOCH_BIAS = 23'd2520114;
    localparam logic [26:0] RECIP_QC   = 27'd120414424; // 4t/146097 = t*K >> 42
    localparam int          SHIFT_QC   = 42;
    localparam logic [17:0] DAYS_QC    = 18'd146097;
    localparam logic [23:0] RECIP_CENT = 24'd11758899;  // 99u/36160 = u*K >> 32
    localparam int          SHIFT_CENT = 32;
    localparam logic [10:0] DAYS_4Y    = 11'd1461;
    localparam logic [14:0] RECIP_MON  = 15'd17135;     // 5t/153 = t*17135 >> 19
    localparam int          SHIFT_MON  = 19;

    // floor(153*mm/5) + day offset of each month, March based
    function automatic logic [8:0] month_start(input logic [MONTH_W-1:0] month);
        logic [8:0] res;
        unique case (month)
            4'd1:    res = 9'd428;
            4'd2:    res = 9'd459;
            4'd3:    res = 9'd122;
            4'd4:    res = 9'd153;
            4'd5:    res = 9'd183;
            4'd6:    res = 9'd214;
            4'd7:    res = 9'd244;
            4'd8:    res = 9'd275;
            4'd9:    res = 9'd306;
            4'd10:   res = 9'd336;
            4'd11:   res = 9'd367;
            4'd12:   res = 9'd397;
            default: res = 9'd0;
        endcase
        return res;
    endfunction

    // floor(367*mo/12)
    function automatic logic [8:0] mo_start(input logic [3:0] mo);
        logic [8:0] res;
        unique case (mo)
            4'd0:    res = 9'd0;
            4'd1:    res = 9'd30;
            4'd2:    res = 9'd61;
            4'd3:    res = 9'd91;
            4'd4:    res = 9'd122;
            4'd5:    res = 9'd152;
            4'd6:    res = 9'd183;
            4'd7:    res = 9'd214;
            4'd8:    res = 9'd244;
            4'd9:    res = 9'd275;
            4'd10:   res = 9'd305;
            4'd11:   res = 9'd336;
            4'd12:   res = 9'd367;
            4'd13:   res = 9'd397;
            default: res = 9'd0;
        endcase
        return res;
    endfunction

endpackage

[hw/rtl/gregorian_day_number_converter.sv]
// ----------------------------------------------------------------------------
// gregorian_day_number_converter
// Proleptic Gregorian date <-> signed day number (2000-01-01 is day 0).
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit first)                         | tuser
//  s_      | in  | year 14, month 4, day 5, day_number 23, pad 2 | func
//  m_      | out | day_count 23, year_out 14, month_out 4,       | range_error
//          |     | day_out 5, pad 2                              |
//
//  One beat per cycle in, one per cycle out while m_tready stays high.
//  Both functions share one pipeline of seven register stages; the
//  constant-reciprocal multiplies and wide adds are spread across them.
//  aresetn clears the stage valid bits only.
//  Each stage holds while the one after it is full and stalled, so bubbles
//  close up and s_tready stays high while any stage is empty.
// ----------------------------------------------------------------------------
module gregorian_day_number_converter (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // year[13:0], month[17:14], day[22:18], day_number[45:23]
    input  logic [gdnc_pkg::S_TDATA_W-1:0] s_tdata,
    // func[0]
    input  logic [0:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // day_count[22:0], year_out[36:23], month_out[40:37], day_out[45:41]
    output logic [gdnc_pkg::M_TDATA_W-1:0] m_tdata,
    // range_error[0]
    output logic [0:0]                     m_tuser
);
    import gdnc_pkg::*;

    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] adv;

    always_comb begin
        adv[NUM_STAGES-1] = !vld_reg[NUM_STAGES-1] || m_tready;
        for (int i = NUM_STAGES - 2; i >= 0; i--) begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (adv[0]) begin
                vld_reg[0] <= s_tvalid;
            end
            for (int i = 1; i < NUM_STAGES; i++) begin
                if (adv[i]) begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    assign s_tready = adv[0];
    assign m_tvalid = vld_reg[NUM_STAGES-1];

    // func and error flag ride along with every stage
    logic [NUM_STAGES-1:0] func_reg;
    logic [NUM_STAGES-1:0] err_reg;

    // ---------------- stage 1: unpack, range check, offsets ----------------
    logic [YEAR_W-1:0]          in_year;
    logic [MONTH_W-1:0]         in_month;
    logic [DAY_W-1:0]           in_day;
    logic signed [DAYNUM_W-1:0] in_dn;
    logic                       in_func;
    logic                       err_next;
    logic                       early;
    logic [14:0]                yy_next;
    logic [8:0]                 dayadd_next;
    logic [22:0]                t_next;

    assign in_year  = s_tdata[13:0];
    assign in_month = s_tdata[17:14];
    assign in_day   = s_tdata[22:18];
    assign in_dn    = signed'(s_tdata[45:23]);
    assign in_func  = s_tuser[0];

    always_comb begin
        if (in_func == FUNC_TO_DAYS) begin
            err_next = (in_year == '0) || (in_year > YEAR_MAX) || (in_month == '0) ||
                       (in_month > MONTH_MAX) || (in_day == '0);
        end else begin
            err_next = (in_dn < DAYNUM_MIN) || (in_dn > DAYNUM_MAX);
        end
        early       = (in_month <= 4'd2);
        yy_next     = 15'(in_year) + YEAR_BIAS - 15'(early);
        dayadd_next = 9'(in_day) + month_start(in_month);
        t_next      = unsigned'(in_dn) + EPOCH_BIAS;
    end

    // flags advance with their stage
    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            func_reg[0] <= in_func;
            err_reg[0]  <= err_next;
        end
        for (int i = 1; i < NUM_STAGES; i++) begin
            if (adv[i]) begin
                func_reg[i] <= func_reg[i-1];
                err_reg[i]  <= err_reg[i-1];
            end
        end
    end

    logic [14:0] st1_yy_reg;
    logic [8:0]  st1_dayadd_reg;
    logic [22:0] st1_t_reg;

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            st1_yy_reg     <= yy_next;
            st1_dayadd_reg <= dayadd_next;
            st1_t_reg      <= t_next;
        end
    end

    // ---------------- stage 2: year products, 400-year cycle ----------------
    logic [23:0] p365;
    logic [27:0] p100;
    logic [49:0] pqc;

    assign p365 = 24'(st1_yy_reg) * 24'(DAYS_YEAR);
    assign p100 = 28'(st1_yy_reg) * 28'(RECIP_100);
    assign pqc  = 50'(st1_t_reg) * 50'(RECIP_QC);

    logic [22:0] st2_p365_reg;
    logic [7:0]  st2_q100_reg;
    logic [12:0] st2_q4_reg;
    logic [8:0]  st2_dayadd_reg;
    logic [7:0]  st2_q_reg;
    logic [22:0] st2_t_reg;

    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            st2_p365_reg   <= p365[22:0];
            st2_q100_reg   <= p100[SHIFT_100+7:SHIFT_100];
            st2_q4_reg     <= st1_yy_reg[14:2];
            st2_dayadd_reg <= st1_dayadd_reg;
            st2_q_reg      <= pqc[SHIFT_QC+7:SHIFT_QC];
            st2_t_reg      <= st1_t_reg;
        end
    end

    // ---------------- stage 3: partial sums, day within cycle ----------------
    logic [22:0] sum_a_next;
    logic [12:0] sum_b_next;
    logic [25:0] rq;
    logic [25:0] r_cyc;

    always_comb begin
        sum_a_next = 23'(st2_dayadd_reg) + st2_p365_reg;
        sum_b_next = st2_q4_reg - 13'(st2_q100_reg) + 13'(st2_q100_reg[7:2]);
        rq         = 26'(st2_q_reg) * 26'(DAYS_QC);
        // 4t - 146097q; the day within the cycle is that over four
        r_cyc      = {1'b0, st2_t_reg, 2'b00} - rq;
    end

    logic [22:0] st3_sum_a_reg;
    logic [12:0] st3_sum_b_reg;
    logic [15:0] st3_t1_reg;
    logic [7:0]  st3_q_reg;

    always_ff @(posedge aclk) begin
        if (adv[2]) begin
            st3_sum_a_reg <= sum_a_next;
            st3_sum_b_reg <= sum_b_next;
            st3_t1_reg    <= r_cyc[17:2];
            st3_q_reg     <= st2_q_reg;
        end
    end

    // ---------------- stage 4: day count, century ----------------
    logic [22:0] days_next;
    logic [16:0] u_cent;
    logic [40:0] pcent;

    always_comb begin
        days_next = st3_sum_a_reg + 23'(st3_sum_b_reg) - DAYS_BIAS;
        u_cent    = 17'(st3_t1_reg) + 17'd1;
        pcent     = 41'(u_cent) * 41'(RECIP_CENT);
    end

    logic [22:0] st4_days_reg;
    logic [15:0] st4_t1_reg;
    logic [7:0]  st4_q_reg;
    logic [6:0]  st4_c_reg;

    always_ff @(posedge aclk) begin
        if (adv[3]) begin
            st4_days_reg <= days_next;
            st4_t1_reg   <= st3_t1_reg;
            st4_q_reg    <= st3_q_reg;
            st4_c_reg    <= pcent[SHIFT_CENT+6:SHIFT_CENT];
        end
    end

    // ---------------- stage 5: day within year, year base ----------------
    logic [17:0] p1461;
    logic [17:0] t2_wide;
    logic [15:0] yb_wide;

    always_comb begin
        p1461   = 18'(st4_c_reg) * 18'(DAYS_4Y);
        t2_wide = 18'(st4_t1_reg) - 18'(p1461[17:2]) + 18'd31;
        yb_wide = 16'(st4_q_reg) * 16'd100 + 16'(st4_c_reg) - 16'd4900;
    end

    logic [22:0] st5_days_reg;
    logic [9:0]  st5_t2_reg;
    logic [13:0] st5_yb_reg;

    always_ff @(posedge aclk) begin
        if (adv[4]) begin
            st5_days_reg <= st4_days_reg;
            st5_t2_reg   <= t2_wide[9:0];
            st5_yb_reg   <= yb_wide[13:0];
        end
    end

    // ---------------- stage 6: March-based month ----------------
    logic [24:0] pmon;

    assign pmon = 25'(st5_t2_reg) * 25'(RECIP_MON);

    logic [22:0] st6_days_reg;
    logic [9:0]  st6_t2_reg;
    logic [13:0] st6_yb_reg;
    logic [3:0]  st6_mo_reg;

    always_ff @(posedge aclk) begin
        if (adv[5]) begin
            st6_days_reg <= st5_days_reg;
            st6_t2_reg   <= st5_t2_reg;
            st6_yb_reg   <= st5_yb_reg;
            st6_mo_reg   <= pmon[SHIFT_MON+3:SHIFT_MON];
        end
    end

    // ---------------- stage 7: date fields, output register ----------------
    logic                  wrap;
    logic [MONTH_W-1:0]    month_calc;
    logic [9:0]            day_wide;
    logic [YEAR_W-1:0]     year_calc;
    logic [DAYNUM_W-1:0]   day_count_next;
    logic [YEAR_W-1:0]     year_out_next;
    logic [MONTH_W-1:0]    month_out_next;
    logic [DAY_W-1:0]      day_out_next;

    always_comb begin
        // January and February fall at the end of the March-based year
        wrap       = (st6_mo_reg >= 4'd11);
        month_calc = st6_mo_reg + 4'd2 - (wrap ? 4'd12 : 4'd0);
        day_wide   = st6_t2_reg - 10'(mo_start(st6_mo_reg));
        year_calc  = st6_yb_reg + 14'(wrap);

        day_count_next = '0;
        year_out_next  = '0;
        month_out_next = '0;
        day_out_next   = '0;
        if (!err_reg[5]) begin
            if (func_reg[5] == FUNC_TO_DAYS) begin
                day_count_next = st6_days_reg;
            end else begin
                year_out_next  = year_calc;
                month_out_next = month_calc;
                day_out_next   = day_wide[4:0];
            end
        end
    end

    logic [DAYNUM_W-1:0] day_count_reg;
    logic [YEAR_W-1:0]   year_out_reg;
    logic [MONTH_W-1:0]  month_out_reg;
    logic [DAY_W-1:0]    day_out_reg;

    always_ff @(posedge aclk) begin
        if (adv[6]) begin
            day_count_reg <= day_count_next;
            year_out_reg  <= year_out_next;
            month_out_reg <= month_out_next;
            day_out_reg   <= day_out_next;
        end
    end

    assign m_tdata = {2'b00, day_out_reg, month_out_reg, year_out_reg, day_count_reg};
    assign m_tuser = {err_reg[6] & (func_reg[6] | !func_reg[6])};

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for gregorian_day_number_converter. A directed table
// covers the calendar limits, range errors, unused fields and day overflow
// past the month end. Random dates and day numbers follow, with some noise
// beats. Both sides of the stream idle at random. Every result beat is
// compared with a fixed table value or an in-bench model of the conversion.
// ----------------------------------------------------------------------------
module tb;
    import gdnc_pkg::*;

    localparam int N_DIR      = 25;
    localparam int N_RANDOM   = 1250;
    localparam int CYCLE_CAP  = 400000;
    localparam int DRAIN_WAIT = 3 * NUM_STAGES;

    typedef struct packed {
        logic                       func;
        logic [YEAR_W-1:0]          year;
        logic [MONTH_W-1:0]         month;
        logic [DAY_W-1:0]           day;
        logic signed [DAYNUM_W-1:0] day_number;
    } conv_in_t;

    typedef struct packed {
        logic signed [DAYNUM_W-1:0] day_count;
        logic [YEAR_W-1:0]          year_out;
        logic [MONTH_W-1:0]         month_out;
        logic [DAY_W-1:0]           day_out;
        logic                       range_error;
    } conv_out_t;

    typedef struct packed {
        conv_in_t  stim;
        logic      fixed;
        conv_out_t want;
    } dir_row_t;

    localparam conv_out_t NO_RESULT  = '0;
    localparam conv_out_t OUT_OF_RNG = '{range_error: 1'b1, default: '0};
    localparam conv_out_t MILLENNIUM = '{year_out: 14'd2000, month_out: 4'd1,
                                         day_out: 5'd1, default: '0};

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [0:0]           s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [0:0]           m_tuser;

    conv_out_t awaited_conversions[$];
    int        mismatches  = 0;
    int        cycles      = 0;
    bit        quiet_phase = 1'b0;

    gregorian_day_number_converter uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // Conversion in 64-bit integers; every operand is positive, so
    // truncating division matches floor.
    function automatic conv_out_t calendar_convert(input conv_in_t it);
        conv_out_t res;
        longint    a, mm, yy, t, q, c, mo, n;
        res = NO_RESULT;
        if (it.func == FUNC_TO_DAYS) begin
            if (it.year < 1 || it.year > 9999 || it.month < 1 || it.month > 12 ||
                it.day < 1) begin
                res.range_error = 1'b1;
            end else begin
                a  = (14 - longint'(it.month)) / 12;
                mm = longint'(it.month) + 12 * a + 1;
                yy = longint'(it.year) + 4800 - a;
                res.day_count = DAYNUM_W'(longint'(it.day) + (153 * mm) / 5 + 365 * yy
                                          + yy / 4 - yy / 100 + yy / 400 - 2483712);
            end
        end else begin
            n = longint'(it.day_number);
            if (n < -730119 || n > 2921939) begin
                res.range_error = 1'b1;
            end else begin
                t  = n + 2520114;
                q  = (t * 4) / 146097;
                t  = t - (146097 * q + 3) / 4;
                c  = (99 * (t + 1)) / 36160;
                t  = t - ((1461 * c) / 4 - 31);
                mo = (5 * t) / 153;
                a  = mo / 11;
                res.day_out   = DAY_W'(t - (367 * mo) / 12);
                res.month_out = MONTH_W'(mo - 12 * a + 2);
                res.year_out  = YEAR_W'(100 * (q - 49) + c + a);
            end
        end
        return res;
    endfunction

    // mostly back-to-back or short gaps, the odd long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_phase || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    task automatic send_beat(input conv_in_t it, input logic fixed, input conv_out_t want);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= it.func;
        s_tdata  <= {2'b00, it.day_number, it.day, it.month, it.year};
        do @(posedge aclk); while (!s_tready);
        awaited_conversions.push_back(fixed ? want : calendar_convert(it));
        gap = idle_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // receiver back-pressure
    initial begin
        int stall;
        forever begin
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge aclk);
            stall = idle_len();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        conv_out_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.day_count   = m_tdata[22:0];
            got.year_out    = m_tdata[36:23];
            got.month_out   = m_tdata[40:37];
            got.day_out     = m_tdata[45:41];
            got.range_error = m_tuser[0];
            if (awaited_conversions.size() == 0) begin
                $error("result beat with nothing outstanding");
                mismatches++;
            end else begin
                want = awaited_conversions.pop_front();
                if (got.day_count !== want.day_count) begin
                    $error("day_count: expected %0d, got %0d", want.day_count, got.day_count);
                    mismatches++;
                end
                if (got.year_out !== want.year_out) begin
                    $error("year_out: expected %0d, got %0d", want.year_out, got.year_out);
                    mismatches++;
                end
                if (got.month_out !== want.month_out) begin
                    $error("month_out: expected %0d, got %0d", want.month_out, got.month_out);
                    mismatches++;
                end
                if (got.day_out !== want.day_out) begin
                    $error("day_out: expected %0d, got %0d", want.day_out, got.day_out);
                    mismatches++;
                end
                if (got.range_error !== want.range_error) begin
                    $error("range_error: expected %0d, got %0d",
                           want.range_error, got.range_error);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        dir_row_t dir_rows [N_DIR];
        conv_in_t it;
        int       pick;

        dir_rows = '{
            '{'{FUNC_TO_DAYS, 14'd2000,  4'd1,  5'd1,  23'sd0},        1'b1, NO_RESULT},
            '{'{FUNC_TO_DATE, 14'd0,     4'd0,  5'd0,  23'sd0},        1'b1, MILLENNIUM},
            '{'{FUNC_TO_DAYS, 14'd1,     4'd1,  5'd1,  23'sd0},        1'b1,
              '{day_count: -23'sd730119, default: '0}},
            '{'{FUNC_TO_DAYS, 14'd9999,  4'd12, 5'd31, 23'sd0},        1'b1,
              '{day_count: 23'sd2921939, default: '0}},
            '{'{FUNC_TO_DATE, 14'd0,     4'd0,  5'd0,  -23'sd730119},  1'b1,
              '{year_out: 14'd1, month_out: 4'd1, day_out: 5'd1, default: '0}},
            '{'{FUNC_TO_DATE, 14'd0,     4'd0,  5'd0,  23'sd2921939},  1'b1,
              '{year_out: 14'd9999, month_out: 4'd12, day_out: 5'd31, default: '0}},
            '{'{FUNC_TO_DAYS, 14'd0,     4'd1,  5'd1,  23'sd0},        1'b1, OUT_OF_RNG},
            '{'{FUNC_TO_DAYS, 14'd10000, 4'd6,  5'd15, 23'sd0},        1'b1, OUT_OF_RNG},
            '{'{FUNC_TO_DAYS, 14'd16383, 4'd15, 5'd31, -23'sd1},       1'b1, OUT_OF_RNG},
            '{'{FUNC_TO_DAYS, 14'd2024,  4'd0,  5'd10, 23'sd0},        1'b1, OUT_OF_RNG},
            '{'{FUNC_TO_DAYS, 14'd2024,  4'd13, 5'd10, 23'sd0},        1'b1, OUT_OF_RNG},
            '{'{FUNC_TO_DAYS, 14'd2024,  4'd5,  5'd0,  23'sd0},        1'b1, OUT_OF_RNG},
            '{'{FUNC_TO_DATE, 14'd0,     4'd0,  5'd0,  -23'sd730120},  1'b1, OUT_OF_RNG},
            '{'{FUNC_TO_DATE, 14'd0,     4'd0,  5'd0,  23'sd2921940},  1'b1, OUT_OF_RNG},
            '{'{FUNC_TO_DATE, 14'd0,     4'd0,  5'd0,  -23'sd4194304}, 1'b1, OUT_OF_RNG},
            '{'{FUNC_TO_DATE, 14'd0,     4'd0,  5'd0,  23'sd4194303},  1'b1, OUT_OF_RNG},
            // day past the month end rolls into the next month
            '{'{FUNC_TO_DAYS, 14'd2001,  4'd2,  5'd31, 23'sd0},        1'b0, NO_RESULT},
            '{'{FUNC_TO_DAYS, 14'd2000,  4'd2,  5'd29, 23'sd0},        1'b0, NO_RESULT},
            '{'{FUNC_TO_DAYS, 14'd1900,  4'd2,  5'd29, 23'sd0},        1'b0, NO_RESULT},
            '{'{FUNC_TO_DAYS, 14'd2000,  4'd3,  5'd1,  23'sd0},        1'b0, NO_RESULT},
            '{'{FUNC_TO_DATE, 14'd0,     4'd0,  5'd0,  -23'sd1},       1'b0, NO_RESULT},
            '{'{FUNC_TO_DATE, 14'd0,     4'd0,  5'd0,  23'sd59},       1'b0, NO_RESULT},
            // fields of the other function are don't-care
            '{'{FUNC_TO_DATE, 14'd16383, 4'd15, 5'd31, 23'sd0},        1'b1, MILLENNIUM},
            '{'{FUNC_TO_DAYS, 14'd2000,  4'd1,  5'd1,  23'sd4194303},  1'b1, NO_RESULT},
            '{'{FUNC_TO_DAYS, 14'd1,     4'd12, 5'd31, -23'sd4194304}, 1'b0, NO_RESULT}
        };

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i])
            send_beat(dir_rows[i].stim, dir_rows[i].fixed, dir_rows[i].want);

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i % 100 == 0)
                quiet_phase = ($urandom_range(0, 3) == 0);
            it.year       = YEAR_W'($urandom);
            it.month      = MONTH_W'($urandom);
            it.day        = DAY_W'($urandom);
            it.day_number = DAYNUM_W'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                it.func  = FUNC_TO_DAYS;
                it.month = MONTH_W'($urandom_range(1, 12));
                it.day   = DAY_W'($urandom_range(1, 31));
                if ($urandom_range(0, 9) == 0)
                    it.year = YEAR_W'($urandom_range(0, 1) ? $urandom_range(1, 3)
                                                           : $urandom_range(9997, 9999));
                else
                    it.year = YEAR_W'($urandom_range(1, 9999));
            end else if (pick < 80) begin
                it.func = FUNC_TO_DATE;
                if ($urandom_range(0, 9) == 0)
                    it.day_number = DAYNUM_W'($urandom_range(0, 1)
                                              ? -730119 + $urandom_range(0, 3)
                                              : 2921939 - $urandom_range(0, 3));
                else
                    it.day_number = DAYNUM_W'(int'($urandom_range(0, 3652058)) - 730119);
            end else begin
                it.func = 1'($urandom);
            end
            send_beat(it, 1'b0, NO_RESULT);
        end
        s_tvalid <= 1'b0;

        while (awaited_conversions.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (mismatches == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

[gregorian_day_number_converter.f]
hw/rtl/gdnc_pkg.sv
hw/rtl/gregorian_day_number_converter.sv
tb/tb.sv
